// ===== rtl/jsu_pkg.sv =====
// Shared types and constants for the JSON string unescaper.
package jsu_pkg;

  // Parser phase, encoded as in the 3-bit state register.
  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_BODY = 3'd1,
    PH_ESC  = 3'd2,
    PH_HEX1 = 3'd3,
    PH_HEX2 = 3'd4,
    PH_HEX3 = 3'd5,
    PH_HEX4 = 3'd6
  } phase_t;

  // Result kinds seen on the output channel.
  typedef enum logic [2:0] {
    K_BYTE    = 3'd0,
    K_END     = 3'd1,
    K_NUL     = 3'd2,
    K_BADESC  = 3'd3,
    K_BADHEX  = 3'd4,
    K_NOQUOTE = 3'd5
  } kind_t;

  // Input characters with a meaning of their own.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  // Bytes the single-letter escapes stand for.
  localparam logic [7:0] BY_BS  = 8'h08;
  localparam logic [7:0] BY_FF  = 8'h0C;
  localparam logic [7:0] BY_LF  = 8'h0A;
  localparam logic [7:0] BY_CR  = 8'h0D;
  localparam logic [7:0] BY_TAB = 8'h09;

  // UTF-8 encoding limits and prefixes.
  localparam logic [15:0] CP_ONE_LIMIT = 16'h0080;
  localparam logic [15:0] CP_TWO_LIMIT = 16'h0800;
  localparam logic [7:0]  UTF_LEAD2    = 8'hC0;
  localparam logic [7:0]  UTF_LEAD3    = 8'hE0;
  localparam logic [7:0]  UTF_CONT     = 8'h80;
  localparam logic [7:0]  UTF_CMASK    = 8'h3F;

  // Queue between front and back; depth must be a power of two.
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // One queue entry: all results caused by one input item.
  typedef struct packed {
    logic [1:0] cnt;   // 1..3 results
    kind_t      kind;  // kind shared by every result of the entry
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } qent_t;

  typedef struct packed {
    logic  push;
    qent_t ent;
  } push_t;

  typedef struct packed {
    logic  valid;
    qent_t ent;
  } head_t;

endpackage

// ===== rtl/jsu_in_if.sv =====
// Input channel: one raw string byte per item.
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink   (input valid, input char_in, output ready);
endinterface

// ===== rtl/jsu_out_if.sv =====
// Output channel: one decoded result per item.
interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [2:0] result_kind;
  logic       last;

  modport source (output valid, output out_byte, output result_kind, output last,
                  input ready);
  modport sink   (input valid, input out_byte, input result_kind, input last,
                  output ready);
endinterface

// ===== rtl/jsu_front.sv =====
// Front end: accepts input bytes, runs the parser state, builds queue entries.
module jsu_front (
  input  logic              clk,
  input  logic              rst,
  jsu_in_if.sink            chars,
  input  logic              q_full,
  output jsu_pkg::push_t    push
);

  jsu_pkg::phase_t phase, phase_next;
  logic [15:0]     code_point, code_point_next;
  jsu_pkg::qent_t  ent;
  logic            acc;
  logic [7:0]      c;
  logic [4:0]      hv;
  logic [15:0]     cp_shift;

  // {valid, nibble}
  function automatic logic [4:0] hex_val(input logic [7:0] ch);
    logic [4:0] r;
    r = '0;
    if (ch inside {[8'h30:8'h39]}) begin
      r = {1'b1, 4'(ch - 8'h30)};
    end else if (ch inside {[8'h61:8'h66]}) begin
      r = {1'b1, 4'(ch - 8'h57)};
    end else if (ch inside {[8'h41:8'h46]}) begin
      r = {1'b1, 4'(ch - 8'h37)};
    end
    return r;
  endfunction

  assign c           = chars.char_in;
  assign chars.ready = !q_full;
  assign acc         = chars.valid && !q_full;
  assign hv          = hex_val(c);
  assign cp_shift    = {code_point[11:0], hv[3:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= jsu_pkg::PH_IDLE;
      code_point <= '0;
    end else if (acc) begin
      phase      <= phase_next;
      code_point <= code_point_next;
    end
  end

  always_comb begin
    phase_next      = phase;
    code_point_next = code_point;
    ent.cnt  = 2'd0;
    ent.kind = jsu_pkg::K_BYTE;
    ent.b0   = '0;
    ent.b1   = '0;
    ent.b2   = '0;
    case (phase)
      jsu_pkg::PH_BODY: begin
        if (c == jsu_pkg::CH_NUL) begin
          ent.cnt    = 2'd1;
          ent.kind   = jsu_pkg::K_NUL;
          phase_next = jsu_pkg::PH_IDLE;
        end else if (c == jsu_pkg::CH_QUOTE) begin
          ent.cnt    = 2'd1;
          ent.kind   = jsu_pkg::K_END;
          phase_next = jsu_pkg::PH_IDLE;
        end else if (c == jsu_pkg::CH_BSLASH) begin
          phase_next = jsu_pkg::PH_ESC;
        end else begin
          ent.cnt = 2'd1;
          ent.b0  = c;
        end
      end
      jsu_pkg::PH_ESC: begin
        phase_next = jsu_pkg::PH_BODY;
        ent.cnt    = 2'd1;
        case (c)
          jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH: ent.b0 = c;
          jsu_pkg::CH_B: ent.b0 = jsu_pkg::BY_BS;
          jsu_pkg::CH_F: ent.b0 = jsu_pkg::BY_FF;
          jsu_pkg::CH_N: ent.b0 = jsu_pkg::BY_LF;
          jsu_pkg::CH_R: ent.b0 = jsu_pkg::BY_CR;
          jsu_pkg::CH_T: ent.b0 = jsu_pkg::BY_TAB;
          jsu_pkg::CH_U: begin
            ent.cnt         = 2'd0;
            code_point_next = '0;
            phase_next      = jsu_pkg::PH_HEX1;
          end
          default: begin
            ent.kind   = (c == jsu_pkg::CH_NUL) ? jsu_pkg::K_NUL : jsu_pkg::K_BADESC;
            phase_next = jsu_pkg::PH_IDLE;
          end
        endcase
      end
      jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2, jsu_pkg::PH_HEX3, jsu_pkg::PH_HEX4: begin
        if (!hv[4]) begin
          ent.cnt    = 2'd1;
          ent.kind   = (c == jsu_pkg::CH_NUL) ? jsu_pkg::K_NUL : jsu_pkg::K_BADHEX;
          phase_next = jsu_pkg::PH_IDLE;
        end else begin
          code_point_next = cp_shift;
          case (phase)
            jsu_pkg::PH_HEX1: phase_next = jsu_pkg::PH_HEX2;
            jsu_pkg::PH_HEX2: phase_next = jsu_pkg::PH_HEX3;
            jsu_pkg::PH_HEX3: phase_next = jsu_pkg::PH_HEX4;
            default: begin
              phase_next = jsu_pkg::PH_BODY;
              if (cp_shift < jsu_pkg::CP_ONE_LIMIT) begin
                ent.cnt = 2'd1;
                ent.b0  = cp_shift[7:0];
              end else if (cp_shift < jsu_pkg::CP_TWO_LIMIT) begin
                ent.cnt = 2'd2;
                ent.b0  = jsu_pkg::UTF_LEAD2 | {3'b000, cp_shift[10:6]};
                ent.b1  = jsu_pkg::UTF_CONT | (cp_shift[7:0] & jsu_pkg::UTF_CMASK);
              end else begin
                ent.cnt = 2'd3;
                ent.b0  = jsu_pkg::UTF_LEAD3 | {4'b0000, cp_shift[15:12]};
                ent.b1  = jsu_pkg::UTF_CONT | {2'b00, cp_shift[11:6]};
                ent.b2  = jsu_pkg::UTF_CONT | (cp_shift[7:0] & jsu_pkg::UTF_CMASK);
              end
            end
          endcase
        end
      end
      default: begin
        // idle (and the unused code): wait for the opening quote
        if (c == jsu_pkg::CH_QUOTE) begin
          phase_next = jsu_pkg::PH_BODY;
        end else begin
          ent.cnt    = 2'd1;
          ent.kind   = jsu_pkg::K_NOQUOTE;
          phase_next = jsu_pkg::PH_IDLE;
        end
      end
    endcase
  end

  assign push.push = acc && (ent.cnt != 2'd0);
  assign push.ent  = ent;

endmodule

// ===== rtl/jsu_queue.sv =====
// Short entry queue between the front and back ends.
module jsu_queue (
  input  logic           clk,
  input  logic           rst,
  input  jsu_pkg::push_t push,
  input  logic           pop,
  output logic           full,
  output jsu_pkg::head_t head
);

  jsu_pkg::qent_t             mem [jsu_pkg::QDEPTH];
  logic [jsu_pkg::QAW-1:0]    wr_ptr, rd_ptr;
  logic [jsu_pkg::QAW:0]      count;

  assign full       = (count == (jsu_pkg::QAW+1)'(jsu_pkg::QDEPTH));
  assign head.valid = (count != '0);
  assign head.ent   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.push) begin
      mem[wr_ptr] <= push.ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)       rd_ptr <= rd_ptr + 1'b1;
      if (push.push && !pop)      count <= count + 1'b1;
      else if (!push.push && pop) count <= count - 1'b1;
    end
  end

endmodule

// ===== rtl/jsu_back.sv =====
// Back end: splits queue entries into single results behind an output register.
module jsu_back (
  input  logic           clk,
  input  logic           rst,
  input  jsu_pkg::head_t head,
  output logic           pop,
  jsu_out_if.source      results
);

  logic            ov;
  logic [7:0]      ob;
  jsu_pkg::kind_t  okind;
  logic            olast;
  logic [1:0]      idx;
  logic            load, is_last;
  logic [7:0]      sel;

  assign load    = head.valid && (!ov || results.ready);
  assign is_last = (idx == 2'(head.ent.cnt - 2'd1));
  assign pop     = load && is_last;

  always_comb begin
    case (idx)
      2'd0:    sel = head.ent.b0;
      2'd1:    sel = head.ent.b1;
      default: sel = head.ent.b2;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov  <= 1'b0;
      idx <= '0;
    end else if (load) begin
      ov  <= 1'b1;
      idx <= is_last ? 2'd0 : idx + 2'd1;
    end else if (results.ready) begin
      ov  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ob    <= sel;
      okind <= head.ent.kind;
      olast <= is_last;
    end
  end

  assign results.valid       = ov;
  assign results.out_byte    = ob;
  assign results.result_kind = okind;
  assign results.last        = olast;

endmodule

// ===== rtl/json_string_unescape_utf8.sv =====
// Top level of the JSON string unescaper: front end, entry queue, back end.
// Path: a byte's results are written into the entry queue, then loaded into the output register.
// Throughput: one byte in per cycle and one result out per cycle while the receiver is ready;
// a \u escape that yields two or three UTF-8 bytes sends them out one by one, and input
// stalls only when the four-entry queue is full.
// Reset (synchronous, rst high): parser idle, code point zero, queue empty, no output.
module json_string_unescape_utf8 (
  input  logic       clk,
  input  logic       rst,
  jsu_in_if.sink     chars,
  jsu_out_if.source  results
);

  // Front to queue: one entry per input byte that causes results.
  jsu_pkg::push_t push;
  // Queue to back: oldest entry, popped after its last result is loaded.
  jsu_pkg::head_t head;
  logic           q_full;
  logic           pop;

  // Front: parser phase and code point live here; it never waits on the
  // output, only on queue space.
  jsu_front u_front (
    .clk    (clk),
    .rst    (rst),
    .chars  (chars),
    .q_full (q_full),
    .push   (push)
  );

  // Queue decouples a six-byte escape from the up to three results it produces.
  jsu_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .full (q_full),
    .head (head)
  );

  // Back: walks each entry result by result, marks last on the final one.
  jsu_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .pop     (pop),
    .results (results)
  );

  // No push into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.push |-> !q_full)
    else $error("push into full queue");

  // Every queued entry carries at least one result.
  a_entry_cnt: assert property (@(posedge clk) disable iff (rst)
    head.valid |-> (head.ent.cnt != 2'd0))
    else $error("empty entry in queue");

  // Status results carry a zero byte and are the only result of their byte.
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    (results.valid && (results.result_kind != jsu_pkg::K_BYTE))
      |-> (results.last && (results.out_byte == 8'h00)))
    else $error("status result not last or nonzero byte");

  // A pop happens only with a valid head.
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    pop |-> head.valid)
    else $error("pop from empty queue");

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the JSON string unescaper with UTF-8 output.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Run shape
  localparam int PHASE_ITEMS  = 120;      // least raw bytes queued per idling phase
  localparam int CYCLE_LIMIT  = 200_000;  // hard stop, far above any passing run
  localparam int DRAIN_CYCLES = 16;       // quiet time after the last result

  // ASCII anchors for hex digits
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_LO_A = 8'h61;
  localparam logic [7:0] CH_UP_A = 8'h41;
  localparam logic [7:0] CH_TOP  = 8'hFF;

  // The eight single-letter escapes
  localparam logic [7:0] SIMPLE_ESC [8] = '{jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH,
                                            jsu_pkg::CH_SLASH, jsu_pkg::CH_B,
                                            jsu_pkg::CH_F, jsu_pkg::CH_N,
                                            jsu_pkg::CH_R, jsu_pkg::CH_T};

  // Code points on the UTF-8 length boundaries, plus a lone surrogate
  localparam logic [15:0] CP_EDGES [6] = '{16'h007F, 16'h0080, 16'h07FF,
                                           16'h0800, 16'hD800, 16'hFFFF};

  // Directed opening: every result kind, the byte extremes and \u0000
  localparam logic [7:0] OPENING_SEQ [26] = '{
    CH_UP_A, jsu_pkg::CH_NUL,                                 // junk and NUL while idle
    jsu_pkg::CH_QUOTE, CH_TOP, jsu_pkg::CH_NUL,               // 0xFF passes, NUL in body
    jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, CH_UP_A,           // unknown escape letter
    jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_U,
    jsu_pkg::CH_U,                                            // non-hex in \u
    jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_U,
    CH_ZERO, CH_ZERO, CH_ZERO, CH_ZERO,                       // \u0000
    jsu_pkg::CH_BSLASH, jsu_pkg::CH_U, jsu_pkg::CH_F, CH_UP_A + 8'd5,
    jsu_pkg::CH_F, CH_UP_A + 8'd5,                            // \uFFFF, three bytes
    jsu_pkg::CH_QUOTE                                         // string end
  };

  typedef enum {GAP_NONE, GAP_SENDER, GAP_RECEIVER, GAP_BOTH} gap_mode_t;

  // One decoded result as it should appear on the output channel
  typedef struct packed {
    logic [7:0]     out_byte;
    jsu_pkg::kind_t kind;
    logic           last;
  } result_t;

  logic clk = 1'b0;
  logic rst;

  jsu_in_if  chars_if ();
  jsu_out_if results_if ();

  json_string_unescape_utf8 u_dut (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars_if),
    .results (results_if)
  );

  logic [7:0] raw_q [$];      // string bytes waiting to be sent
  result_t    decoded_q [$];  // results owed by the block, oldest first

  // Mirror of the parser state
  jsu_pkg::phase_t str_phase = jsu_pkg::PH_IDLE;
  logic [15:0]     cp_acc    = '0;

  gap_mode_t gap_mode  = GAP_NONE;
  int        err_cnt   = 0;
  int        cycle_cnt = 0;
  result_t   want;

  initial begin
    forever #5 clk = ~clk;
  end

  // -1 for anything that is not a hex digit
  function automatic int hex_digit_value(logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_ZERO + 8'd9) return int'(c - CH_ZERO);
    if (c >= CH_LO_A && c <= CH_LO_A + 8'd5) return int'(c - CH_LO_A) + 10;
    if (c >= CH_UP_A && c <= CH_UP_A + 8'd5) return int'(c - CH_UP_A) + 10;
    return -1;
  endfunction

  // Hex digit with random letter case
  function automatic logic [7:0] hex_char(logic [3:0] v);
    if (v < 4'd10) return CH_ZERO + 8'(v);
    return ($urandom_range(0, 1) ? CH_UP_A : CH_LO_A) + 8'(v - 4'd10);
  endfunction

  // Advance the parser mirror by one accepted byte and queue what it owes.
  function automatic void unescape_char(logic [7:0] c);
    result_t outs [$];
    int      h;
    h = hex_digit_value(c);
    case (str_phase)
      jsu_pkg::PH_BODY: begin
        if (c == jsu_pkg::CH_NUL) begin
          outs.push_back(result_t'{8'h00, jsu_pkg::K_NUL, 1'b0});
          str_phase = jsu_pkg::PH_IDLE;
        end else if (c == jsu_pkg::CH_QUOTE) begin
          outs.push_back(result_t'{8'h00, jsu_pkg::K_END, 1'b0});
          str_phase = jsu_pkg::PH_IDLE;
        end else if (c == jsu_pkg::CH_BSLASH) begin
          str_phase = jsu_pkg::PH_ESC;
        end else begin
          outs.push_back(result_t'{c, jsu_pkg::K_BYTE, 1'b0});
        end
      end
      jsu_pkg::PH_ESC: begin
        str_phase = jsu_pkg::PH_BODY;
        case (c)
          jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH:
            outs.push_back(result_t'{c, jsu_pkg::K_BYTE, 1'b0});
          jsu_pkg::CH_B: outs.push_back(result_t'{jsu_pkg::BY_BS, jsu_pkg::K_BYTE, 1'b0});
          jsu_pkg::CH_F: outs.push_back(result_t'{jsu_pkg::BY_FF, jsu_pkg::K_BYTE, 1'b0});
          jsu_pkg::CH_N: outs.push_back(result_t'{jsu_pkg::BY_LF, jsu_pkg::K_BYTE, 1'b0});
          jsu_pkg::CH_R: outs.push_back(result_t'{jsu_pkg::BY_CR, jsu_pkg::K_BYTE, 1'b0});
          jsu_pkg::CH_T: outs.push_back(result_t'{jsu_pkg::BY_TAB, jsu_pkg::K_BYTE, 1'b0});
          jsu_pkg::CH_U: begin
            cp_acc    = '0;
            str_phase = jsu_pkg::PH_HEX1;
          end
          default: begin
            outs.push_back(result_t'{8'h00, (c == jsu_pkg::CH_NUL) ? jsu_pkg::K_NUL
                                                                : jsu_pkg::K_BADESC, 1'b0});
            str_phase = jsu_pkg::PH_IDLE;
          end
        endcase
      end
      jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2, jsu_pkg::PH_HEX3, jsu_pkg::PH_HEX4: begin
        if (h < 0) begin
          outs.push_back(result_t'{8'h00, (c == jsu_pkg::CH_NUL) ? jsu_pkg::K_NUL
                                                              : jsu_pkg::K_BADHEX, 1'b0});
          str_phase = jsu_pkg::PH_IDLE;
        end else begin
          cp_acc = {cp_acc[11:0], 4'(h)};
          if (str_phase != jsu_pkg::PH_HEX4) begin
            str_phase = jsu_pkg::phase_t'(str_phase + 3'd1);
          end else begin
            // UTF-8: one, two or three bytes by code point size
            if (cp_acc < jsu_pkg::CP_ONE_LIMIT) begin
              outs.push_back(result_t'{cp_acc[7:0], jsu_pkg::K_BYTE, 1'b0});
            end else if (cp_acc < jsu_pkg::CP_TWO_LIMIT) begin
              outs.push_back(result_t'{jsu_pkg::UTF_LEAD2 | 8'(cp_acc >> 6),
                                       jsu_pkg::K_BYTE, 1'b0});
              outs.push_back(result_t'{jsu_pkg::UTF_CONT | (cp_acc[7:0] & jsu_pkg::UTF_CMASK),
                                       jsu_pkg::K_BYTE, 1'b0});
            end else begin
              outs.push_back(result_t'{jsu_pkg::UTF_LEAD3 | 8'(cp_acc >> 12),
                                       jsu_pkg::K_BYTE, 1'b0});
              outs.push_back(result_t'{jsu_pkg::UTF_CONT |
                                       (8'(cp_acc >> 6) & jsu_pkg::UTF_CMASK),
                                       jsu_pkg::K_BYTE, 1'b0});
              outs.push_back(result_t'{jsu_pkg::UTF_CONT | (cp_acc[7:0] & jsu_pkg::UTF_CMASK),
                                       jsu_pkg::K_BYTE, 1'b0});
            end
            str_phase = jsu_pkg::PH_BODY;
          end
        end
      end
      default: begin
        // idle: only an opening quote is welcome
        if (c == jsu_pkg::CH_QUOTE) begin
          str_phase = jsu_pkg::PH_BODY;
        end else begin
          outs.push_back(result_t'{8'h00, jsu_pkg::K_NOQUOTE, 1'b0});
          str_phase = jsu_pkg::PH_IDLE;
        end
      end
    endcase
    if (outs.size() != 0) outs[outs.size() - 1].last = 1'b1;
    foreach (outs[i]) decoded_q.push_back(outs[i]);
  endfunction

  // Queue one string literal: mostly well formed with random content; some
  // are preceded by junk, some break off with NUL, a bad escape or bad hex.
  function automatic void queue_string();
    int          parts;
    int          fault;
    int          fault_at;
    int          digits;
    int          pick;
    logic [15:0] cp;
    logic [7:0]  c;
    bit          is_bad;
    parts    = $urandom_range(0, 10);
    fault    = ($urandom_range(0, 99) < 20) ? $urandom_range(1, 4) : 0;
    fault_at = $urandom_range(0, parts);
    digits   = $urandom_range(0, 3);
    if (fault == 4) begin
      // stray byte before the opening quote, then a clean string
      do c = 8'($urandom_range(0, 255)); while (c == jsu_pkg::CH_QUOTE);
      raw_q.push_back(c);
      fault = 0;
    end
    raw_q.push_back(jsu_pkg::CH_QUOTE);
    for (int i = 0; i < parts; i++) begin
      if (fault != 0 && i == fault_at) break;
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        do c = 8'($urandom_range(1, 255));
        while (c == jsu_pkg::CH_QUOTE || c == jsu_pkg::CH_BSLASH);
        raw_q.push_back(c);
      end else if (pick < 7) begin
        raw_q.push_back(jsu_pkg::CH_BSLASH);
        raw_q.push_back(SIMPLE_ESC[$urandom_range(0, 7)]);
      end else begin
        case ($urandom_range(0, 3))
          0:       cp = 16'($urandom_range(0, 16'h007F));
          1:       cp = 16'($urandom_range(16'h0080, 16'h07FF));
          2:       cp = 16'($urandom_range(16'h0800, 16'hFFFF));
          default: cp = CP_EDGES[$urandom_range(0, 5)];
        endcase
        raw_q.push_back(jsu_pkg::CH_BSLASH);
        raw_q.push_back(jsu_pkg::CH_U);
        for (int d = 3; d >= 0; d--) raw_q.push_back(hex_char(cp[d*4 +: 4]));
      end
    end
    case (fault)
      1: begin
        // NUL in the body, right after a backslash, or in place of a hex digit
        pick = $urandom_range(0, 2);
        if (pick > 0) raw_q.push_back(jsu_pkg::CH_BSLASH);
        if (pick > 1) begin
          raw_q.push_back(jsu_pkg::CH_U);
          repeat (digits) raw_q.push_back(hex_char(4'($urandom_range(0, 15))));
        end
        raw_q.push_back(jsu_pkg::CH_NUL);
      end
      2: begin
        do begin
          c = 8'($urandom_range(1, 255));
          case (c)
            jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH, jsu_pkg::CH_B,
            jsu_pkg::CH_F, jsu_pkg::CH_N, jsu_pkg::CH_R, jsu_pkg::CH_T, jsu_pkg::CH_U:
              is_bad = 1'b0;
            default: is_bad = 1'b1;
          endcase
        end while (!is_bad);
        raw_q.push_back(jsu_pkg::CH_BSLASH);
        raw_q.push_back(c);
      end
      3: begin
        raw_q.push_back(jsu_pkg::CH_BSLASH);
        raw_q.push_back(jsu_pkg::CH_U);
        repeat (digits) raw_q.push_back(hex_char(4'($urandom_range(0, 15))));
        do c = 8'($urandom_range(1, 255)); while (hex_digit_value(c) >= 0);
        raw_q.push_back(c);
      end
      default: raw_q.push_back(jsu_pkg::CH_QUOTE);
    endcase
  endfunction

  // Random hold-off for either side of the block under the current phase
  function automatic bit hold_off(bit receiver_side);
    int pct;
    case (gap_mode)
      GAP_SENDER:   pct = receiver_side ? 0 : 58;
      GAP_RECEIVER: pct = receiver_side ? 58 : 0;
      GAP_BOTH:     pct = 33;
      default:      pct = 0;
    endcase
    return $urandom_range(0, 99) < pct;
  endfunction

  // Driver: predicts on every accepted item, holds an item until it is
  // taken, and otherwise presents the next byte or idles at random.
  always @(posedge clk) begin
    if (rst) begin
      chars_if.valid   <= 1'b0;
      chars_if.char_in <= '0;
      str_phase = jsu_pkg::PH_IDLE;
      cp_acc    = '0;
    end else begin
      if (chars_if.valid && chars_if.ready) unescape_char(chars_if.char_in);
      if (chars_if.valid && !chars_if.ready) begin
        // stalled: keep the item on the bus
      end else if (raw_q.size() != 0 && !hold_off(1'b0)) begin
        chars_if.valid   <= 1'b1;
        chars_if.char_in <= raw_q.pop_front();
      end else begin
        chars_if.valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each accepted result against the oldest owed one.
  always @(posedge clk) begin
    if (rst) begin
      results_if.ready <= 1'b0;
    end else begin
      if (results_if.valid && results_if.ready) begin
        if (decoded_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result byte=%h kind=%0d last=%b", $time,
                   results_if.out_byte, results_if.result_kind, results_if.last);
        end else begin
          want = decoded_q.pop_front();
          if (results_if.out_byte !== want.out_byte ||
              results_if.result_kind !== want.kind ||
              results_if.last !== want.last) begin
            err_cnt++;
            $display("%0t: expected byte=%h kind=%0d last=%b, got %h/%0d/%b",
                     $time, want.out_byte, want.kind, want.last, results_if.out_byte,
                     results_if.result_kind, results_if.last);
          end
        end
      end
      results_if.ready <= !hold_off(1'b1);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Sequencer: reset, then four idling phases, each drained before the next.
  initial begin
    rst              = 1'b1;
    chars_if.valid   = 1'b0;
    chars_if.char_in = '0;
    results_if.ready = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    foreach (OPENING_SEQ[i]) raw_q.push_back(OPENING_SEQ[i]);
    for (int p = 0; p < 4; p++) begin
      // fill and switch modes at the falling edge, away from the clocked blocks
      @(negedge clk);
      gap_mode = gap_mode_t'(p);
      while (raw_q.size() < PHASE_ITEMS) queue_string();
      while (raw_q.size() != 0 || chars_if.valid || decoded_q.size() != 0)
        @(negedge clk);
    end
    // any late extra result is flagged by the monitor during this wait
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (err_cnt == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
